/* rtl/mqpw_pkg.sv */
// ----------------------------------------------------------------------------
// mqpw_pkg
// Shared types and constants of the priority-waiter message queue.
// ----------------------------------------------------------------------------
package mqpw_pkg;

    localparam int REQ_W  = 2;
    localparam int PRIO_W = 5;
    localparam int STAT_W = 3;
    localparam int MSG_W  = 32;
    localparam int LEN_W  = 5;

    // Queue length after reset.
    localparam logic [LEN_W-1:0] QLEN_RESET = LEN_W'(16);

    typedef enum logic [REQ_W-1:0] {
        REQ_SEND    = 2'd0,
        REQ_RECV    = 2'd1,
        REQ_WD_SEND = 2'd2,
        REQ_WD_RECV = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_REFUSED = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_WOKEN   = 3'd4
    } t_status;

    // Result of a search for the most urgent waiter in a bitmap.
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
    } t_wake;

endpackage

/* rtl/mqpw_prio_enc.sv */
// ----------------------------------------------------------------------------
// mqpw_prio_enc
// Finds the highest set bit of a waiter bitmap.
// ----------------------------------------------------------------------------
module mqpw_prio_enc #(
    parameter int PRIORITIES = 32
) (
    input  logic [PRIORITIES-1:0] i_map,
    output mqpw_pkg::t_wake       o_wake
);
    import mqpw_pkg::*;

    always_comb begin
        o_wake = '0;
        // Later bits overwrite earlier ones, so the top set bit wins.
        for (int i = 0; i < PRIORITIES; i++) begin
            if (i_map[i]) begin
                o_wake.found = 1'b1;
                o_wake.prio  = PRIO_W'(i);
            end
        end
    end

endmodule

/* rtl/mqpw_store.sv */
// ----------------------------------------------------------------------------
// mqpw_store
// Message ring storage with a registered read port that fetches ahead.
// ----------------------------------------------------------------------------
module mqpw_store #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int SLOT_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    import mqpw_pkg::*;

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // The read address is the head slot of the next cycle; a write to that
        // same slot is forwarded so the head word is never stale.
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/message_queue_with_priority_waiters.sv */
// ----------------------------------------------------------------------------
// message_queue_with_priority_waiters
// Hardware mailbox: a message ring plus bitmaps of blocked senders and
// receivers, one bit per task priority.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the input channel (i_valid / o_stall) and each produces
// exactly one result transaction on the output channel (o_valid / i_stall).
// A request is captured in an input register, and once the result register
// is free or being taken, a single pass updates the count, the ring slots
// and both waiter bitmaps and loads the result register, which drives
// o_valid. One request is taken every cycle while the receiver does not
// stall; the next request reads the queue state that the pass updated.
// The head message is prefetched from the ring into a register, so a
// receive does not wait for a memory read.
// When the receiver stalls, the result register holds its transaction and
// the input register still accepts one more request; after that o_stall
// rises until the result is taken.
// Reset (synchronous, active low) empties the queue, clears both bitmaps and sets the slot limit to 16.
// The slot limit is written through the APB port at any address with paddr[2] clear; the user must
// write it only while no request is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module message_queue_with_priority_waiters #(
    parameter int DEPTH      = 16,
    parameter int MSG_BITS   = 32,
    parameter int PRIORITIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mqpw_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mqpw_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic                          i_may_block,
    input  logic [mqpw_pkg::MSG_W-1:0]    i_message_in,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mqpw_pkg::STAT_W-1:0]   o_status,
    output logic [mqpw_pkg::MSG_W-1:0]    o_message_out,
    output logic                          o_woke_valid,
    output logic [mqpw_pkg::PRIO_W-1:0]   o_woke_priority,
    output logic                          o_preempt,
    output logic [mqpw_pkg::LEN_W-1:0]    o_fill_level,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mqpw_pkg::*;

    localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORE_W   = (MSG_BITS < MSG_W) ? MSG_BITS : MSG_W;
    localparam int PIDX_W    = $clog2(PRIORITIES);
    localparam int DEPTH_CAP = (DEPTH > 31) ? 31 : DEPTH;
    localparam int CMP_W     = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 1;

    // Configuration
    logic [LEN_W-1:0] r_qlen;
    logic             cfg_wr;
    logic [LEN_W-1:0] len;

    // Queue state
    logic [SLOT_W-1:0]     r_wslot, n_wslot;
    logic [SLOT_W-1:0]     r_rslot, n_rslot;
    logic [LEN_W-1:0]      r_count, n_count;
    logic [PRIORITIES-1:0] r_snd_wait, n_snd_wait;
    logic [PRIORITIES-1:0] r_rcv_wait, n_rcv_wait;

    // Input register
    logic              r_in_valid;
    t_req              r_req;
    logic [PRIO_W-1:0] r_prio;
    logic              r_blk;
    logic [MSG_W-1:0]  r_msg;

    // Result register
    logic              r_out_valid;
    t_status           r_status;
    logic [MSG_W-1:0]  r_mout;
    logic              r_woke;
    logic [PRIO_W-1:0] r_wprio;
    logic              r_preempt;
    logic [LEN_W-1:0]  r_fill;

    // Processing pass
    logic              advance;
    logic              fire;
    logic              in_accept;
    logic [PRIO_W-1:0] prio_c;
    logic [PRIORITIES-1:0] pbit;
    logic [PRIORITIES-1:0] wake_clr;
    t_wake             snd_wake, rcv_wake;
    t_status           n_status;
    logic [MSG_W-1:0]  n_mout;
    logic              n_woke;
    logic [PRIO_W-1:0] n_wprio;
    logic              store_wr;
    logic [STORE_W-1:0] head_data;

    function automatic logic [SLOT_W-1:0] f_next_slot(
        input logic [SLOT_W-1:0] s,
        input logic [LEN_W-1:0]  l
    );
        logic [CMP_W-1:0] n;
        n = CMP_W'(s) + CMP_W'(1);
        return (n >= CMP_W'(l)) ? '0 : SLOT_W'(n);
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(r_qlen);

    always_comb begin
        if (r_qlen == '0) begin
            len = LEN_W'(1);
        end else if (r_qlen > LEN_W'(DEPTH_CAP)) begin
            len = LEN_W'(DEPTH_CAP);
        end else begin
            len = r_qlen;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign advance   = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && advance;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Waiter search
    // ------------------------------------------------------------------
    mqpw_prio_enc #(.PRIORITIES(PRIORITIES)) u_snd_enc (
        .i_map  (r_snd_wait),
        .o_wake (snd_wake)
    );

    mqpw_prio_enc #(.PRIORITIES(PRIORITIES)) u_rcv_enc (
        .i_map  (r_rcv_wait),
        .o_wake (rcv_wake)
    );

    // ------------------------------------------------------------------
    // Message ring
    // ------------------------------------------------------------------
    mqpw_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (STORE_W),
        .SLOT_W (SLOT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_wslot),
        .i_wr_data (STORE_W'(r_msg)),
        .i_rd_addr (n_rslot),
        .o_rd_data (head_data)
    );

    // ------------------------------------------------------------------
    // Request processing
    // ------------------------------------------------------------------
    always_comb begin
        prio_c = (r_prio > PRIO_W'(PRIORITIES - 1)) ? PRIO_W'(PRIORITIES - 1) : r_prio;
        pbit   = '0;
        pbit[PIDX_W'(prio_c)] = 1'b1;

        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_count    = r_count;
        n_snd_wait = r_snd_wait;
        n_rcv_wait = r_rcv_wait;
        n_status   = ST_REFUSED;
        n_mout     = '0;
        n_woke     = 1'b0;
        n_wprio    = '0;
        store_wr   = 1'b0;
        wake_clr   = '0;

        if (fire) begin
            case (r_req)
                REQ_SEND: begin
                    if (r_count < len) begin
                        store_wr = 1'b1;
                        n_wslot  = f_next_slot(r_wslot, len);
                        n_count  = r_count + LEN_W'(1);
                        n_status = ST_DONE;
                        if (rcv_wake.found) begin
                            n_woke   = 1'b1;
                            n_wprio  = rcv_wake.prio;
                            wake_clr[PIDX_W'(rcv_wake.prio)] = 1'b1;
                        end
                        n_rcv_wait = r_rcv_wait & ~wake_clr;
                    end else if ((r_count == len) && r_blk) begin
                        n_snd_wait = r_snd_wait | pbit;
                        n_status   = ST_BLOCKED;
                    end
                end
                REQ_RECV: begin
                    if (r_count != '0) begin
                        n_mout   = MSG_W'(head_data);
                        n_rslot  = f_next_slot(r_rslot, len);
                        n_count  = r_count - LEN_W'(1);
                        n_status = ST_DONE;
                        if (snd_wake.found) begin
                            n_woke   = 1'b1;
                            n_wprio  = snd_wake.prio;
                            wake_clr[PIDX_W'(snd_wake.prio)] = 1'b1;
                        end
                        n_snd_wait = r_snd_wait & ~wake_clr;
                    end else if (r_blk) begin
                        n_rcv_wait = r_rcv_wait | pbit;
                        n_status   = ST_BLOCKED;
                    end
                end
                REQ_WD_SEND: begin
                    if ((r_snd_wait & pbit) != '0) begin
                        n_snd_wait = r_snd_wait & ~pbit;
                        n_status   = ST_TIMEOUT;
                    end else begin
                        n_status   = ST_WOKEN;
                    end
                end
                REQ_WD_RECV: begin
                    if ((r_rcv_wait & pbit) != '0) begin
                        n_rcv_wait = r_rcv_wait & ~pbit;
                        n_status   = ST_TIMEOUT;
                    end else begin
                        n_status   = ST_WOKEN;
                    end
                end
                default: begin
                    n_status = ST_REFUSED;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen      <= QLEN_RESET;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_count     <= '0;
            r_snd_wait  <= '0;
            r_rcv_wait  <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_qlen <= pwdata[LEN_W-1:0];
            end
            r_wslot    <= n_wslot;
            r_rslot    <= n_rslot;
            r_count    <= n_count;
            r_snd_wait <= n_snd_wait;
            r_rcv_wait <= n_rcv_wait;
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req  <= t_req'(i_req_type);
            r_prio <= i_task_priority;
            r_blk  <= i_may_block;
            r_msg  <= i_message_in;
        end
        if (fire) begin
            r_status  <= n_status;
            r_mout    <= n_mout;
            r_woke    <= n_woke;
            r_wprio   <= n_wprio;
            r_preempt <= n_woke && (n_wprio > prio_c);
            r_fill    <= n_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_message_out   = r_mout;
    assign o_woke_valid    = r_woke;
    assign o_woke_priority = r_wprio;
    assign o_preempt       = r_preempt;
    assign o_fill_level    = r_fill;

endmodule

/* rtl/mqpw_checker.sv */
// ----------------------------------------------------------------------------
// mqpw_checker
// Port-level checks of the priority-waiter message queue.
// ----------------------------------------------------------------------------
module mqpw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [mqpw_pkg::STAT_W-1:0]   o_status,
    input logic [mqpw_pkg::MSG_W-1:0]    o_message_out,
    input logic                          o_woke_valid,
    input logic [mqpw_pkg::PRIO_W-1:0]   o_woke_priority,
    input logic                          o_preempt
);
    import mqpw_pkg::*;

    // A stalled result transaction stays presented.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status) && $stable(o_message_out))
        else $error("stalled result changed");

    // Only a completed send or receive wakes a waiter or returns data.
    a_wake_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> !o_woke_valid && (o_message_out == '0))
        else $error("wake or data on a request that did not complete");

    // Without a woken task there is no preemption and no woken priority.
    a_no_wake_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_woke_valid |-> !o_preempt && (o_woke_priority == '0))
        else $error("preempt or priority without a woken task");

endmodule

bind message_queue_with_priority_waiters mqpw_checker u_mqpw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_message_out   (o_message_out),
    .o_woke_valid    (o_woke_valid),
    .o_woke_priority (o_woke_priority),
    .o_preempt       (o_preempt)
);
